// ===== src/bhpq_pkg.sv =====
`default_nettype none
package bhpq_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxBits  = $clog2(Capacity);
  localparam int unsigned CntBits  = IdxBits + 1;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned TagBits  = 16;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [TagBits-1:0] tag;
  } entry_t;
endpackage
`default_nettype wire

// ===== src/binary_heap_priority_queue.sv =====
// Binary heap priority queue, up to 1024 entries of a 32-bit key and a 16-bit tag, held in
// one memory with one write and one read port and registered read data. Pulse start with
// an opcode when busy is low; exactly one result beat follows on done_o, which the
// receiver cannot stall and must take in that cycle. An error goes straight to the done
// and wait states, and a read reads its slot first. An insert sifts up with a parent read,
// then a compare and write, per level; a remove sifts down with two child reads, a read
// wait, then a compare and write, per level, the child reads going one after the other over
// the single memory read port. cfg_wdata_i picks max or min heap; the user must write it
// only while the block is idle, and the block itself does not enforce this.
`default_nettype none
module binary_heap_priority_queue import bhpq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [KeyBits-1:0] entry_key_i,
  input  wire logic [TagBits-1:0] entry_tag_i,
  input  wire logic [IdxBits-1:0] position_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [KeyBits-1:0]      out_key_o,
  output logic [TagBits-1:0]      out_tag_o,
  output logic [CntBits-1:0]      entry_count_o
);

  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SRdPos  = 11'b00000000010,
    SRdLast = 11'b00000000100,
    SUpRd   = 11'b00000001000,
    SUpCmp  = 11'b00000010000,
    SDnRdL  = 11'b00000100000,
    SDnRdR  = 11'b00001000000,
    SDnCmp  = 11'b00010000000,
    SDnLat  = 11'b00100000000,
    SDone   = 11'b01000000000,
    SWait   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic order_q;
  logic [CntBits-1:0] cnt_q, cnt_d;

  entry_t mem [Capacity];
  entry_t rdata_q;
  logic              re, we;
  logic [IdxBits-1:0] raddr, waddr;
  entry_t            wdata;

  logic [1:0]         op_q, op_d;
  logic [IdxBits-1:0] pos_q, pos_d;
  logic [IdxBits-1:0] j_q, j_d;
  entry_t             cur_q, cur_d;
  entry_t             res_q, res_d;
  entry_t             lch_q, lch_d;
  logic [1:0]         st_q, st_d;

  logic [CntBits-1:0] lidx, ridx;
  logic [IdxBits-1:0] par;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  function automatic logic beats(entry_t a, entry_t b, logic mn);
    beats = mn ? (a.key < b.key) : (a.key > b.key);
  endfunction

  assign lidx = {j_q, 1'b1};
  assign ridx = {j_q, 1'b0} + CntBits'(2);
  assign par  = (j_q - IdxBits'(1)) >> 1;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; op_d = op_q; pos_d = pos_q; j_d = j_q;
    cur_d = cur_q; res_d = res_q; lch_d = lch_q; st_d = st_q;
    re = 1'b0; we = 1'b0; raddr = j_q; waddr = j_q; wdata = cur_q;
    unique case (state_q)
      SIdle: if (start) begin
        op_d = opcode_i; pos_d = position_i; res_d = '0; st_d = StOk;
        if (opcode_i == OpInsert) begin
          if (cnt_q >= CntBits'(Capacity)) begin
            st_d = StFull; state_d = SDone;
          end else begin
            cur_d = '{key: entry_key_i, tag: entry_tag_i};
            j_d = cnt_q[IdxBits-1:0];
            cnt_d = cnt_q + CntBits'(1);
            state_d = SUpRd;
          end
        end else if ((opcode_i == OpRemove || opcode_i == OpRead)
                     && {1'b0, position_i} < cnt_q) begin
          re = 1'b1; raddr = position_i; state_d = SRdPos;
        end else begin
          st_d = StRange; state_d = SDone;
        end
      end
      SRdPos: begin
        res_d = rdata_q;
        if (op_q == OpRead) state_d = SDone;
        else begin
          cnt_d = cnt_q - CntBits'(1);
          if ({1'b0, pos_q} == cnt_q - CntBits'(1)) state_d = SDone;
          else begin
            re = 1'b1; raddr = cnt_d[IdxBits-1:0]; state_d = SRdLast;
          end
        end
      end
      SRdLast: begin
        cur_d = rdata_q; j_d = pos_q; state_d = SDnRdL;
      end
      SDnRdL: begin
        if (lidx < cnt_q) begin
          re = 1'b1; raddr = lidx[IdxBits-1:0]; state_d = SDnRdR;
        end else state_d = SUpRd;
      end
      SDnRdR: begin
        lch_d = rdata_q;
        if (ridx < cnt_q) begin
          re = 1'b1; raddr = ridx[IdxBits-1:0]; state_d = SDnLat;
        end else state_d = SDnCmp;
      end
      SDnLat: state_d = SDnCmp;
      SDnCmp: begin
        logic ub;
        logic [IdxBits-1:0] bi;
        entry_t be;
        ub = beats(lch_q, cur_q, order_q);
        be = ub ? lch_q : cur_q;
        bi = lidx[IdxBits-1:0];
        if (ridx < cnt_q && beats(rdata_q, be, order_q)) begin
          ub = 1'b1; be = rdata_q; bi = ridx[IdxBits-1:0];
        end
        if (ub) begin
          we = 1'b1; waddr = j_q; wdata = be; j_d = bi; state_d = SDnRdL;
        end else state_d = SUpRd;
      end
      SUpRd: begin
        if (j_q == '0) begin
          we = 1'b1; state_d = SDone;
        end else begin
          re = 1'b1; raddr = par; state_d = SUpCmp;
        end
      end
      SUpCmp: begin
        if (beats(cur_q, rdata_q, order_q)) begin
          we = 1'b1; wdata = rdata_q; j_d = par; state_d = SUpRd;
        end else begin
          we = 1'b1; state_d = SDone;
        end
      end
      SDone: state_d = SWait;
      SWait: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; order_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      if (cfg_we_i) order_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; pos_q <= pos_d; j_q <= j_d; cur_q <= cur_d;
    res_q <= res_d; lch_q <= lch_d; st_q <= st_d;
  end

  assign busy          = (state_q != SIdle);
  assign done_o        = (state_q == SWait);
  assign status_o      = st_q;
  assign out_key_o     = res_q.key;
  assign out_tag_o     = res_q.tag;
  assign entry_count_o = cnt_q;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(Capacity)) else $error("count overflow");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StFull |-> cnt_q == CntBits'(Capacity)) else $error("bad full");
`endif
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench import bhpq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpIllegal = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 80;

  typedef struct packed {
    logic [1:0]         status;
    logic [KeyBits-1:0] key;
    logic [TagBits-1:0] tag;
    logic [CntBits-1:0] count;
  } heap_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               start;
  logic               busy;
  logic [1:0]         opcode_i;
  logic [KeyBits-1:0] entry_key_i;
  logic [TagBits-1:0] entry_tag_i;
  logic [IdxBits-1:0] position_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [KeyBits-1:0] out_key_o;
  logic [TagBits-1:0] out_tag_o;
  logic [CntBits-1:0] entry_count_o;

  binary_heap_priority_queue dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .opcode_i, .entry_key_i, .entry_tag_i, .position_i,
    .done_o, .status_o, .out_key_o, .out_tag_o, .entry_count_o
  );

  entry_t       heap_mem [Capacity];
  int unsigned  heap_fill;
  logic         min_order;
  heap_result_t pending_q [$];
  heap_result_t want;
  heap_result_t got;
  int unsigned  cycle_cnt;
  int unsigned  mismatch_cnt;
  int unsigned  beats_sent;
  int unsigned  beats_checked;
  int unsigned  full_hits;
  int unsigned  range_hits;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit ranks_above(entry_t a, entry_t b);
    return min_order ? (a.key < b.key) : (a.key > b.key);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned j);
    int unsigned up;
    while (j != 0) begin
      up = (j - 1) / 2;
      if (!ranks_above(heap_mem[j], heap_mem[up])) break;
      swap_slots(j, up);
      j = up;
    end
  endfunction

  function automatic int unsigned push_down(int unsigned j);
    int unsigned l, r, best;
    while (j < heap_fill) begin
      l = 2 * j + 1;
      r = 2 * j + 2;
      best = j;
      if (l < heap_fill && ranks_above(heap_mem[l], heap_mem[best])) best = l;
      if (r < heap_fill && ranks_above(heap_mem[r], heap_mem[best])) best = r;
      if (best == j) break;
      swap_slots(j, best);
      j = best;
    end
    return j;
  endfunction

  function automatic heap_result_t heap_apply(logic [1:0] op, logic [KeyBits-1:0] k,
                                              logic [TagBits-1:0] t, logic [IdxBits-1:0] pos);
    heap_result_t r;
    int unsigned last;
    r = '0;
    if (op == OpInsert) begin
      if (heap_fill >= Capacity) begin
        r.status = StFull;
      end else begin
        heap_mem[heap_fill].key = k;
        heap_mem[heap_fill].tag = t;
        heap_fill++;
        bubble_up(heap_fill - 1);
      end
    end else if (op == OpRemove || op == OpRead) begin
      if (pos >= heap_fill) begin
        r.status = StRange;
      end else begin
        r.key = heap_mem[pos].key;
        r.tag = heap_mem[pos].tag;
        if (op == OpRemove) begin
          last = heap_fill - 1;
          heap_fill = last;
          if (pos != last) begin
            heap_mem[pos] = heap_mem[last];
            bubble_up(push_down(pos));
          end
        end
      end
    end else begin
      r.status = StRange;
    end
    r.count = heap_fill[CntBits-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results pending", cycle_cnt, pending_q.size());
        $display("Verification failed");
        $finish;
      end
      if (done_o) begin
        got = '{status_o, out_key_o, out_tag_o, entry_count_o};
        if (pending_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = pending_q.pop_front();
          beats_checked++;
          if (got != want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch at beat %0d: expected st=%0d key=%h tag=%h cnt=%0d",
                       beats_checked, want.status, want.key, want.tag, want.count);
              $display("  got st=%0d key=%h tag=%h cnt=%0d",
                       got.status, got.key, got.tag, got.count);
            end
          end
        end
      end
      if (start && !busy) begin
        want = heap_apply(opcode_i, entry_key_i, entry_tag_i, position_i);
        if (want.status == StFull) full_hits++;
        if (want.status == StRange) range_hits++;
        pending_q.push_back(want);
        beats_sent++;
      end
      if (cfg_we_i) min_order = cfg_wdata_i;
    end
  end

  task automatic issue(logic [1:0] op, logic [KeyBits-1:0] k, logic [TagBits-1:0] t,
                       logic [IdxBits-1:0] pos);
    int unsigned gap;
    gap = $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    entry_key_i <= k;
    entry_tag_i <= t;
    position_i  <= pos;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_order(logic mode);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [IdxBits-1:0] pick_position();
    if (heap_fill > 0 && $urandom_range(0, 99) < 85)
      return IdxBits'($urandom_range(0, heap_fill - 1));
    return IdxBits'($urandom());
  endfunction

  function automatic logic [KeyBits-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hffff_fff8 | $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_and_illegal();
    issue(OpRead, '0, '0, '0);
    issue(OpRemove, '0, '0, '0);
    issue(OpRemove, '1, '1, '1);
    issue(OpIllegal, '1, '1, '1);
  endtask

  task automatic test_directed_ops(logic mode);
    set_order(mode);
    issue(OpInsert, '0, '0, '0);
    issue(OpInsert, '1, '1, '1);
    issue(OpInsert, 32'd5, 16'h1234, '0);
    issue(OpInsert, 32'd5, 16'h5678, '0);
    issue(OpInsert, 32'd5, 16'h9abc, '0);
    issue(OpInsert, 32'h8000_0000, 16'h8000, '0);
    issue(OpRead, '0, '0, 10'd0);
    issue(OpRead, '0, '0, 10'd5);
    issue(OpRead, '0, '0, 10'd6);
    issue(OpIllegal, '0, '0, 10'd0);
    issue(OpRemove, '0, '0, 10'd5);
    issue(OpRemove, '0, '0, 10'd1);
    issue(OpRemove, '0, '0, 10'd0);
    while (heap_fill > 0) issue(OpRemove, '0, '0, 10'd0);
  endtask

  task automatic test_fill_to_capacity();
    set_order(1'b1);
    while (heap_fill < Capacity)
      issue(OpInsert, pick_key(), TagBits'($urandom()), IdxBits'($urandom()));
    issue(OpInsert, '1, '1, '1);
    issue(OpRead, '0, '0, 10'd1023);
    issue(OpRemove, '0, '0, 10'd1023);
    issue(OpInsert, '0, '0, '0);
    repeat (150) issue(OpRemove, '0, '0, pick_position());
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 45)
        issue(OpInsert, pick_key(), TagBits'($urandom()), IdxBits'($urandom()));
      else if (sel < 75)
        issue(OpRemove, $urandom(), TagBits'($urandom()), pick_position());
      else if (sel < 95)
        issue(OpRead, $urandom(), TagBits'($urandom()), pick_position());
      else
        issue(OpIllegal, $urandom(), TagBits'($urandom()), IdxBits'($urandom()));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    start       = 1'b0;
    opcode_i    = '0;
    entry_key_i = '0;
    entry_tag_i = '0;
    position_i  = '0;
    heap_fill   = 0;
    min_order   = 1'b0;
    cycle_cnt   = 0;
    mismatch_cnt = 0;
    beats_sent  = 0;
    beats_checked = 0;
    full_hits   = 0;
    range_hits  = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_illegal();
    test_directed_ops(1'b0);
    test_directed_ops(1'b1);
    test_fill_to_capacity();
    set_order(1'b0);
    test_random_mix(120);
    set_order(1'b1);
    test_random_mix(120);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("%0d beats sent, %0d results checked, %0d full and %0d range errors hit",
             beats_sent, beats_checked, full_hits, range_hits);
    $display("both heap orders, fill to capacity and back, %0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/bhpq_pkg.sv
src/binary_heap_priority_queue.sv
bench/testbench.sv
